### src/png_unf_pkg.sv
// ----------------------------------------------------------------------------
// png_unf_pkg - shared types and constants
// Filter codes, sizing constants and the stage record of the scanline
// unfilter.
// ----------------------------------------------------------------------------
package png_unf_pkg;

  localparam int MAX_LINE_BYTES = 4096;
  localparam int MAX_BPP        = 8;

  localparam int BYTE_W   = 8;
  localparam int BPP_W    = 4;
  localparam int LEN_W    = 13;
  localparam int POS_W    = LEN_W;
  localparam int ADDR_W   = $clog2(MAX_LINE_BYTES);
  localparam int BIDX_W   = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int CFG_W    = LEN_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN = 1'b1;

  localparam logic [BYTE_W-1:0] FILT_MAX_CODE = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_t;

  typedef struct packed {
    logic              is_filt;
    logic [BYTE_W-1:0] data;
    filt_t             filt;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } stage_t;

endpackage

### src/png_unf_in_if.sv
// ----------------------------------------------------------------------------
// png_unf_in_if - filtered byte channel
// Valid/ready channel carrying one stream byte and the image start flag.
// ----------------------------------------------------------------------------
interface png_unf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

### src/png_unf_out_if.sv
// ----------------------------------------------------------------------------
// png_unf_out_if - reconstructed byte channel
// Valid/ready channel carrying one raw image byte with row and error flags.
// ----------------------------------------------------------------------------
interface png_unf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       last_of_row;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output last_of_row, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input last_of_row, input bad_filter,
                  output ready);
endinterface

### src/png_unf_predict.sv
// ----------------------------------------------------------------------------
// png_unf_predict - predictor and reconstruction
// Forms the None/Sub/Up/Average/Paeth predictor and adds it modulo 256.
// ----------------------------------------------------------------------------
module png_unf_predict
  import png_unf_pkg::*;
(
  input  filt_t             filt,
  input  logic [BYTE_W-1:0] data,
  input  logic [BYTE_W-1:0] left,
  input  logic [BYTE_W-1:0] up,
  input  logic [BYTE_W-1:0] upleft,
  output logic [BYTE_W-1:0] result
);

  logic signed [BYTE_W+1:0] da;
  logic signed [BYTE_W+1:0] db;
  logic signed [BYTE_W+1:0] dc;
  logic        [BYTE_W+1:0] pa;
  logic        [BYTE_W+1:0] pb;
  logic        [BYTE_W+1:0] pc;
  logic        [BYTE_W:0]   sum;
  logic        [BYTE_W-1:0] paeth;
  logic        [BYTE_W-1:0] pred;

  always_comb begin
    da = $signed({2'b00, up})   - $signed({2'b00, upleft});
    db = $signed({2'b00, left}) - $signed({2'b00, upleft});
    dc = $signed({2'b00, left}) + $signed({2'b00, up}) - $signed({1'b0, upleft, 1'b0});
    pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
    pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
    pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = left;
    end else if (pb <= pc) begin
      paeth = up;
    end else begin
      paeth = upleft;
    end
    sum = {1'b0, left} + {1'b0, up};
    case (filt)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = sum[BYTE_W:1];
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase
    result = data + pred;
  end

endmodule

### src/png_scanline_unfilter_top.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top - PNG scanline unfilter
// Strips the filter type byte of each row and reconstructs the row bytes
// using the left, up and up-left neighbours, keeping the previous row in a
// row memory.
//
//   channel  | dir | payload                                  | handshake
//   in_chan  | in  | data_byte, start_of_image                | valid/ready
//   out_chan | out | pixel_byte, last_of_row, bad_filter      | valid/ready
//   cfg      | in  | cfg_index, cfg_wdata                     | cfg_we
//
// One item per cycle while out_chan is not stalled; a data byte is valid on
// out_chan once it has passed the stage register and the result register.
// Filter type bytes give no output item.
// Reset clears control and neighbour history; the row memory is not
// cleared and needs no clearing pass.
// A stalled output holds the result register and then the stage register;
// input is taken again as soon as the stage can move.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top
  import png_unf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  png_unf_in_if.sink           in_chan,
  png_unf_out_if.source        out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [BPP_W-1:0]  bpp_r;
  logic [LEN_W-1:0]  len_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              first_r;
  logic              first_nxt;
  filt_t             row_filt_r;
  filt_t             row_filt_nxt;

  stage_t            s1_r;
  stage_t            s1_nxt;
  logic              s1_v_r;
  logic              s1_go;

  logic [BYTE_W-1:0] row_mem [MAX_LINE_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  logic [BYTE_W-1:0] left_hist_r   [MAX_BPP];
  logic [BYTE_W-1:0] upleft_hist_r [MAX_BPP];

  logic              out_v_r;
  logic [BYTE_W-1:0] pix_r;
  logic              last_r;
  logic              bad_r;

  logic              in_ready;
  logic              in_acc;
  logic [POS_W-1:0]  pos_eff;
  logic              first_eff;
  logic              in_is_filt;
  logic [POS_W-1:0]  idx_full;
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W-1:0]  len_eff;
  logic              in_last;
  logic [BIDX_W-1:0] bsel;
  logic [BYTE_W-1:0] left;
  logic [BYTE_W-1:0] up;
  logic [BYTE_W-1:0] upleft;
  logic [BYTE_W-1:0] result;
  logic              wr_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_W'(1);
      len_r <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BPP: bpp_r <= cfg_wdata[BPP_W-1:0];
        CFG_LEN: len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // row position control
  always_comb begin
    s1_go     = s1_v_r && (s1_r.is_filt || !out_v_r || out_chan.ready);
    in_ready  = !s1_v_r || s1_go;
    in_acc    = in_chan.valid && in_ready;
    pos_eff   = in_chan.start_of_image ? '0 : pos_r;
    first_eff = in_chan.start_of_image | first_r;
    in_is_filt = (pos_eff == '0);
    idx_full  = pos_eff - POS_W'(1);
    rd_addr   = (idx_full >= POS_W'(MAX_LINE_BYTES)) ? ADDR_W'(MAX_LINE_BYTES - 1)
                                                       : idx_full[ADDR_W-1:0];
    if (len_r == '0) begin
      len_eff = POS_W'(1);
    end else if (len_r > LEN_W'(MAX_LINE_BYTES)) begin
      len_eff = POS_W'(MAX_LINE_BYTES);
    end else begin
      len_eff = len_r;
    end
    in_last = (pos_eff >= len_eff);

    pos_nxt      = pos_r;
    first_nxt    = first_r;
    row_filt_nxt = row_filt_r;
    if (in_acc) begin
      if (in_is_filt) begin
        pos_nxt      = POS_W'(1);
        first_nxt    = first_eff;
        row_filt_nxt = (in_chan.data_byte > FILT_MAX_CODE) ? FILT_BAD
                                                           : filt_t'(in_chan.data_byte[2:0]);
      end else if (in_last) begin
        pos_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        pos_nxt   = pos_eff + POS_W'(1);
        first_nxt = first_eff;
      end
    end

    s1_nxt.is_filt = in_is_filt;
    s1_nxt.data    = in_chan.data_byte;
    s1_nxt.filt    = row_filt_r;
    s1_nxt.first   = first_eff;
    s1_nxt.last    = in_last;
    s1_nxt.idx     = rd_addr;
  end

  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      first_r    <= 1'b1;
      row_filt_r <= FILT_NONE;
      s1_v_r     <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      first_r    <= first_nxt;
      row_filt_r <= row_filt_nxt;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // previous row memory
  assign wr_en = s1_go && !s1_r.is_filt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[s1_r.idx] <= result;
    end
    if (in_acc) begin
      rd_data_r <= row_mem[rd_addr];
    end
  end

  // neighbour selection
  always_comb begin
    if (bpp_r == '0) begin
      bsel = '0;
    end else if (bpp_r > BPP_W'(MAX_BPP)) begin
      bsel = BIDX_W'(MAX_BPP - 1);
    end else begin
      bsel = BIDX_W'(bpp_r - BPP_W'(1));
    end
    left   = left_hist_r[bsel];
    upleft = upleft_hist_r[bsel];
    up     = s1_r.first ? '0 : rd_data_r;
  end

  png_unf_predict u_predict (
    .filt   (s1_r.filt),
    .data   (s1_r.data),
    .left   (left),
    .up     (up),
    .upleft (upleft),
    .result (result)
  );

  // clear on a filter byte, shift on a data byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_BPP; k++) begin
        left_hist_r[k]   <= '0;
        upleft_hist_r[k] <= '0;
      end
    end else if (s1_go) begin
      if (s1_r.is_filt) begin
        for (int k = 0; k < MAX_BPP; k++) begin
          left_hist_r[k]   <= '0;
          upleft_hist_r[k] <= '0;
        end
      end else begin
        for (int k = MAX_BPP - 1; k > 0; k--) begin
          left_hist_r[k]   <= left_hist_r[k-1];
          upleft_hist_r[k] <= upleft_hist_r[k-1];
        end
        left_hist_r[0]   <= result;
        upleft_hist_r[0] <= up;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (wr_en) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_r  <= result;
      last_r <= s1_r.last;
      bad_r  <= (s1_r.filt == FILT_BAD);
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.pixel_byte  = pix_r;
  assign out_chan.last_of_row = last_r;
  assign out_chan.bad_filter  = bad_r;

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_v_r)
    else $error("result lost on the way to the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_chan.ready) |-> !wr_en)
    else $error("stalled output item overwritten");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_is_filt && wr_en) |-> (rd_addr != s1_r.idx))
    else $error("row memory read and write collide");

  a_filter_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_filt) |=> (pos_r == POS_W'(1)))
    else $error("filter item did not start a row");

endmodule
